// File: hdl/fixed_slot_free_list_allocator_defines.svh
// ----------------------------------------------------------------------------
// Fixed-slot free-list allocator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

// property holds at every edge out of reset
`define FSLA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define FSLA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/fsla_pkg.sv
// ----------------------------------------------------------------------------
// fsla_pkg
// Types and constants shared by the fixed-slot free-list allocator modules.
// ----------------------------------------------------------------------------
package fsla_pkg;

	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = 8;
	localparam int LINK_W    = 9;
	localparam int COUNT_W   = 9;
	localparam int BYTES_W   = 16;
	localparam int OFFSET_W  = 24;
	localparam int OP_W      = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 48;

	localparam logic [COUNT_W-1:0] LIVE_MAX = '1;
	localparam logic [LINK_W-1:0]  SLOT_COUNT_RST = LINK_W'(MAX_SLOTS);
	localparam logic [BYTES_W-1:0] SLOT_BYTES_RST = 16'd16;

	// operation codes
	localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
	localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic load;    // capture request, launch link read
		logic commit;  // apply update, load output register
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;  // output register empty or being drained
	} ctrl_sts_t;

endpackage

// File: hdl/fixed_slot_free_list_allocator.sv
// Fixed-slot free-list allocator. On accepting an item the block launches a read
// of the link at the list head from the synchronous link RAM; once the output
// register is free it applies the allocate, free or locate and loads the output
// register, and only then takes the next item.
// No clearing pass is needed after reset or a slot_count write: per-slot written
// flags make untouched links read as their index-order value at once.
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// Top level: stream request/response ports and configuration write channel.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [fsla_pkg::IN_W-1:0]      s_tdata,   // operation[1:0], slot[9:2], zero
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fsla_pkg::OUT_W-1:0]     m_tdata,   // ok[0], slot_index[8:1],
	                                                  // byte_offset[32:9], live_count[41:33]
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fsla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fsla_pkg::CFG_DAT_W-1:0] cfg_data
);

	fsla_pkg::ctrl_cmd_t cmd;
	fsla_pkg::ctrl_sts_t sts;

	assign cfg_ready = 1'b1;

	fsla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fsla_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: hdl/fsla_ram.sv
// ----------------------------------------------------------------------------
// fsla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsla_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/fsla_ctrl.sv
// ----------------------------------------------------------------------------
// fsla_ctrl
// Request sequencer: accept an item, then commit it once the output is free.
// ----------------------------------------------------------------------------
module fsla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  fsla_pkg::ctrl_sts_t sts,
	output fsla_pkg::ctrl_cmd_t cmd
);

	fsla_pkg::state_t state_q;
	fsla_pkg::state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			fsla_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = fsla_pkg::ST_EXEC;
				end
			end
			fsla_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = fsla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fsla_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: hdl/fsla_dp.sv
// ----------------------------------------------------------------------------
// fsla_dp
// Free-list datapath: link RAM, head and live count, offset multiply, output.
// ----------------------------------------------------------------------------
`include "fixed_slot_free_list_allocator_defines.svh"

module fsla_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fsla_pkg::ctrl_cmd_t                 cmd,
	output fsla_pkg::ctrl_sts_t                 sts,
	input  logic [fsla_pkg::IN_W-1:0]           s_tdata,
	input  logic                                cfg_valid,
	input  logic [fsla_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fsla_pkg::CFG_DAT_W-1:0]      cfg_data,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fsla_pkg::OUT_W-1:0]          m_tdata
);

	localparam int AW = $clog2(fsla_pkg::MAX_SLOTS);

	logic [fsla_pkg::LINK_W-1:0]   slot_count_q;
	logic [fsla_pkg::BYTES_W-1:0]  slot_bytes_q;
	logic [fsla_pkg::LINK_W-1:0]   head_q;
	logic [fsla_pkg::COUNT_W-1:0]  live_q;
	logic [fsla_pkg::MAX_SLOTS-1:0] written_q;
	logic                          rd_written_q;
	logic [fsla_pkg::OP_W-1:0]     op_q;
	logic [fsla_pkg::SLOT_W-1:0]   slot_q;

	logic                          m_valid_q;
	logic                          ok_q;
	logic [fsla_pkg::SLOT_W-1:0]   idx_q;
	logic [fsla_pkg::OFFSET_W-1:0] off_q;
	logic [fsla_pkg::COUNT_W-1:0]  live_out_q;

	logic [fsla_pkg::LINK_W-1:0]   rd_link;
	logic [fsla_pkg::LINK_W-1:0]   next_link;
	logic                          list_ok;
	logic                          slot_ok;
	logic [fsla_pkg::OFFSET_W-1:0] product;
	logic                          ok_d;
	logic [fsla_pkg::SLOT_W-1:0]   idx_d;
	logic [fsla_pkg::OFFSET_W-1:0] off_d;
	logic [fsla_pkg::LINK_W-1:0]   head_d;
	logic [fsla_pkg::COUNT_W-1:0]  live_d;
	logic                          link_we;
	logic                          cfg_count_wr;
	logic [fsla_pkg::LINK_W-1:0]   cfg_count_val;

	fsla_ram #(
		.WIDTH(fsla_pkg::LINK_W),
		.DEPTH(fsla_pkg::MAX_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(slot_q),
		.wdata(head_q),
		.re   (cmd.load),
		.raddr(head_q[AW-1:0]),
		.rdata(rd_link)
	);

	// never-written entries read as their rethread value, index plus one
	assign next_link = rd_written_q ? rd_link : head_q + fsla_pkg::LINK_W'(1);
	assign list_ok   = head_q < slot_count_q;
	assign slot_ok   = {1'b0, slot_q} < slot_count_q;
	assign product   = fsla_pkg::OFFSET_W'(slot_q) * fsla_pkg::OFFSET_W'(slot_bytes_q);
	assign link_we   = cmd.commit && (op_q == fsla_pkg::OP_FREE) && slot_ok;

	always_comb begin
		ok_d   = 1'b0;
		idx_d  = '0;
		off_d  = '0;
		head_d = head_q;
		live_d = live_q;
		unique case (op_q)
			fsla_pkg::OP_ALLOC: begin
				if (list_ok) begin
					ok_d   = 1'b1;
					idx_d  = head_q[fsla_pkg::SLOT_W-1:0];
					head_d = next_link;
					if (live_q != fsla_pkg::LIVE_MAX) begin
						live_d = live_q + fsla_pkg::COUNT_W'(1);
					end
				end
			end
			fsla_pkg::OP_FREE: begin
				if (slot_ok) begin
					ok_d   = 1'b1;
					head_d = {1'b0, slot_q};
					if (live_q != '0) begin
						live_d = live_q - fsla_pkg::COUNT_W'(1);
					end
				end
			end
			fsla_pkg::OP_LOCATE: begin
				if (slot_ok) begin
					ok_d  = 1'b1;
					off_d = product;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	assign cfg_count_wr  = cfg_valid && (cfg_index == fsla_pkg::CFG_SLOT_COUNT);
	assign cfg_count_val = (cfg_data[fsla_pkg::LINK_W-1:0] > fsla_pkg::SLOT_COUNT_RST) ?
		fsla_pkg::SLOT_COUNT_RST : cfg_data[fsla_pkg::LINK_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= fsla_pkg::SLOT_COUNT_RST;
			slot_bytes_q <= fsla_pkg::SLOT_BYTES_RST;
			head_q       <= '0;
			live_q       <= '0;
			written_q    <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_count_wr) begin
				// rethread: list back in index order
				slot_count_q <= cfg_count_val;
				head_q       <= '0;
				live_q       <= '0;
				written_q    <= '0;
			end else if (cmd.commit) begin
				head_q <= head_d;
				live_q <= live_d;
				if (link_we) begin
					written_q[slot_q] <= 1'b1;
				end
			end
			if (cfg_valid && (cfg_index == fsla_pkg::CFG_SLOT_BYTES)) begin
				slot_bytes_q <= cfg_data;
			end
			if (cmd.commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= s_tdata[fsla_pkg::OP_W-1:0];
			slot_q       <= s_tdata[fsla_pkg::OP_W +: fsla_pkg::SLOT_W];
			rd_written_q <= written_q[head_q[AW-1:0]];
		end
		if (cmd.commit) begin
			ok_q       <= ok_d;
			idx_q      <= idx_d;
			off_q      <= off_d;
			live_out_q <= live_d;
		end
	end

	assign sts.out_free = !m_valid_q || m_tready;
	assign m_tvalid     = m_valid_q;
	assign m_tdata      = {6'b0, live_out_q, off_q, idx_q, ok_q};

	`FSLA_ASSERT_ALWAYS(a_head_range, head_q <= fsla_pkg::SLOT_COUNT_RST, "list head beyond pool")
	`FSLA_ASSERT_NEXT(a_commit_out, cmd.commit, m_valid_q, "committed item not presented")
	`FSLA_ASSERT_ALWAYS(a_fail_zero, !m_valid_q || ok_q || (idx_q == '0 && off_q == '0),
		"failed item carries nonzero index or offset")

endmodule

// File: tb/fixed_slot_free_list_allocator_tb.sv
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_tb
// Drives allocate, free and locate items into the free-list allocator and
// checks every result against a cycle-free model of the slot pool. Covers
// empty pool, out-of-range slots, double frees, reserved opcode and
// slot_count / slot_bytes extremes, with random idling and a long output stall.
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fsla_pkg::*;

	localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int LONG_HOLD = 300;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		bit                held_pick;  // free a slot we currently hold
	} pool_req_t;

	typedef struct packed {
		logic                ok;
		logic [SLOT_W-1:0]   slot_index;
		logic [OFFSET_W-1:0] byte_offset;
		logic [COUNT_W-1:0]  live_count;
	} pool_rsp_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	fixed_slot_free_list_allocator dut (.*);

	// pool model state
	logic [LINK_W-1:0]  next_link [MAX_SLOTS];
	logic [LINK_W-1:0]  list_head;
	logic [COUNT_W-1:0] live_total;
	logic [LINK_W-1:0]  cur_slot_count;
	logic [BYTES_W-1:0] cur_slot_bytes;

	pool_req_t         pending [$];
	pool_rsp_t         pool_expect [$];
	logic [SLOT_W-1:0] held [$];

	int unsigned req_issued = 0, req_accepted = 0;
	int unsigned rsp_seen = 0, rsp_acked = 0;
	int unsigned hold_req = 0, hold_done = 0;
	int unsigned req_gap = 0, rsp_gap = 0, hold_left = 0;
	int unsigned in_gap_max = 10, out_gap_max = 10;
	int unsigned mismatches = 0;
	int unsigned gen_slots = MAX_SLOTS;

	initial forever #4 clk = ~clk;

	initial begin
		#5ms;
		$display("[fixed_slot_free_list_allocator] ERROR");
		$finish;
	end

	task automatic rethread_pool();
		for (int i = 0; i < MAX_SLOTS; i++)
			next_link[i] = LINK_W'(i + 1);
		if (cur_slot_count != 0)
			next_link[cur_slot_count - 1] = cur_slot_count;
		list_head = '0;
		live_total = '0;
	endtask

	function automatic pool_rsp_t pool_step(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot);
		pool_rsp_t r;
		r = '0;
		case (op)
			OP_ALLOC: begin
				if (list_head < cur_slot_count) begin
					r.slot_index = list_head[SLOT_W-1:0];
					list_head = next_link[list_head[SLOT_W-1:0]];
					if (live_total != LIVE_MAX)
						live_total++;
					r.ok = 1'b1;
				end
			end
			OP_FREE: begin
				if (slot < cur_slot_count) begin
					next_link[slot] = list_head;
					list_head = LINK_W'(slot);
					if (live_total != 0)
						live_total--;
					r.ok = 1'b1;
				end
			end
			OP_LOCATE: begin
				if (slot < cur_slot_count) begin
					r.byte_offset = OFFSET_W'(slot) * OFFSET_W'(cur_slot_bytes);
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.live_count = live_total;
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// sample handshakes, predict on accepted requests, check results
	always @(posedge clk or negedge arst_n) begin : observe
		pool_rsp_t want;
		logic [LINK_W-1:0] v;
		if (!arst_n) begin
			cur_slot_count = LINK_W'(MAX_SLOTS);
			cur_slot_bytes = SLOT_BYTES_RST;
			rethread_pool();
			pool_expect.delete();
			held.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				rsp_seen++;
				if (pool_expect.size() == 0) begin
					$error("result item with nothing expected: %h", m_tdata);
					mismatches++;
				end else begin
					want = pool_expect.pop_front();
					check_field("ok", want.ok, m_tdata[0]);
					check_field("slot_index", want.slot_index, m_tdata[8:1]);
					check_field("byte_offset", want.byte_offset, m_tdata[32:9]);
					check_field("live_count", want.live_count, m_tdata[41:33]);
					check_field("pad", 0, m_tdata[47:42]);
				end
			end
			if (s_tvalid && s_tready) begin
				req_accepted++;
				want = pool_step(s_tdata[1:0], s_tdata[9:2]);
				pool_expect.push_back(want);
				if (s_tdata[1:0] == OP_ALLOC && want.ok && held.size() < 64)
					held.push_back(want.slot_index);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_SLOT_COUNT) begin
					v = cfg_data[LINK_W-1:0];
					cur_slot_count = (v > MAX_SLOTS) ? LINK_W'(MAX_SLOTS) : v;
					rethread_pool();
					held.delete();
				end else if (cfg_index == CFG_SLOT_BYTES) begin
					cur_slot_bytes = cfg_data;
				end
			end
		end
	end

	// request side: one item at a time out of the pending queue
	always @(negedge clk) begin : drive_req
		pool_req_t cur;
		int k;
		if (arst_n && !(s_tvalid && req_issued != req_accepted)) begin
			if (req_gap != 0) begin
				s_tvalid <= 1'b0;
				req_gap--;
			end else if (pending.size() != 0) begin
				cur = pending.pop_front();
				if (cur.held_pick && held.size() != 0) begin
					k = $urandom_range(0, held.size() - 1);
					cur.slot = held[k];
					held.delete(k);
				end
				s_tdata <= {6'b0, cur.slot, cur.op};
				s_tvalid <= 1'b1;
				req_issued++;
				req_gap = $urandom_range(0, in_gap_max);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				hold_left = LONG_HOLD;
			end
			if (rsp_seen != rsp_acked) begin
				rsp_acked = rsp_seen;
				rsp_gap = $urandom_range(0, out_gap_max);
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rsp_gap != 0) begin
				rsp_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic queue_req(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
			bit held_pick = 1'b0);
		pool_req_t r;
		r.op = op;
		r.slot = slot;
		r.held_pick = held_pick;
		pending.push_back(r);
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || req_issued != req_accepted || pool_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		wait_idle();
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SLOT_COUNT)
			gen_slots = (val[8:0] > MAX_SLOTS) ? MAX_SLOTS : val[8:0];
	endtask

	initial begin : stimulus
		int unsigned r, loc_top;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset configuration: 256 slots of 16 bytes
		queue_req(OP_LOCATE, 8'd0);
		queue_req(OP_LOCATE, 8'd255);
		queue_req(OP_ALLOC, 8'hFF);
		queue_req(OP_ALLOC, 8'd0);
		queue_req(OP_FREE, 8'd1);
		queue_req(OP_FREE, 8'd0);
		queue_req(OP_FREE, 8'd0);      // free at zero live count, also a double free
		queue_req(OP_RESERVED, 8'hFF);

		write_reg(CFG_SLOT_COUNT, 16'd2);
		write_reg(CFG_SLOT_BYTES, 16'hFFFF);
		queue_req(OP_LOCATE, 8'd1);
		queue_req(OP_LOCATE, 8'd2);
		queue_req(OP_ALLOC, 8'd0);
		queue_req(OP_ALLOC, 8'd0);
		queue_req(OP_ALLOC, 8'd0);     // pool empty
		queue_req(OP_FREE, 8'd2);
		queue_req(OP_FREE, 8'd255);
		queue_req(OP_FREE, 8'd0);
		queue_req(OP_ALLOC, 8'h55);

		write_reg(CFG_SLOT_COUNT, 16'd0);
		queue_req(OP_ALLOC, 8'd0);
		queue_req(OP_FREE, 8'd0);
		queue_req(OP_LOCATE, 8'd0);

		// oversized count saturates; zero slot size gives zero offsets
		write_reg(CFG_SLOT_COUNT, 16'h01FF);
		write_reg(CFG_SLOT_BYTES, 16'd0);
		write_reg(CFG_SPARE_A, 16'hFFFF);
		write_reg(CFG_SPARE_B, 16'h0000);
		queue_req(OP_LOCATE, 8'd200);
		queue_req(OP_ALLOC, 8'd0);
		queue_req(OP_LOCATE, 8'd255);

		for (int ph = 0; ph < 5; ph++) begin
			case ($urandom_range(0, 6))
				0: write_reg(CFG_SLOT_COUNT, 16'd1);
				1: write_reg(CFG_SLOT_COUNT, 16'd4);
				2: write_reg(CFG_SLOT_COUNT, 16'd8);
				3: write_reg(CFG_SLOT_COUNT, 16'd37);
				4: write_reg(CFG_SLOT_COUNT, 16'd256);
				5: write_reg(CFG_SLOT_COUNT, 16'($urandom_range(0, 511)));
				default: write_reg(CFG_SLOT_COUNT, 16'($urandom_range(0, 65535)));
			endcase
			case (ph)
				0: write_reg(CFG_SLOT_BYTES, 16'd1);
				1: write_reg(CFG_SLOT_BYTES, 16'hFFFF);
				default: write_reg(CFG_SLOT_BYTES, 16'($urandom_range(0, 65535)));
			endcase
			in_gap_max = (ph == 2 || ph == 3) ? 0 : 10;
			out_gap_max = (ph == 2) ? 0 : 10;
			if (ph == 3)
				hold_req++;
			loc_top = (gen_slots > 255) ? 255 : gen_slots;
			repeat (105) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					queue_req(OP_ALLOC, 8'($urandom_range(0, 255)));
				else if (r < 68)
					queue_req(OP_FREE, 8'($urandom_range(0, 255)), 1'b1);
				else if (r < 76)
					queue_req(OP_FREE, 8'($urandom_range(0, 255)));
				else if (r < 88)
					queue_req(OP_LOCATE, 8'($urandom_range(0, loc_top)));
				else if (r < 95)
					queue_req(OP_LOCATE, 8'($urandom_range(0, 255)));
				else
					queue_req(OP_RESERVED, 8'($urandom_range(0, 255)));
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("[fixed_slot_free_list_allocator] OK");
		else
			$display("[fixed_slot_free_list_allocator] ERROR");
		$finish;
	end

endmodule

// File: fixed_slot_free_list_allocator.f
+incdir+hdl
hdl/fsla_pkg.sv
hdl/fsla_ram.sv
hdl/fsla_ctrl.sv
hdl/fsla_dp.sv
hdl/fixed_slot_free_list_allocator.sv
tb/fixed_slot_free_list_allocator_tb.sv
